[rtl/core/bbsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsr_pkg: shared types and constants for the bad block skip table
// Table geometry, word widths, status codes, sequencer states and the
// request bundle that drives the table RAM.
// ----------------------------------------------------------------------------
package bbsr_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int BLOCK_BITS  = 12;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Word field widths
    localparam int PHYS_W   = BLOCK_BITS + 1;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Command codes
    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_MARK = 1'b1;

    typedef logic [BLOCK_BITS-1:0] block_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED   = 3'd0,
        ST_INSERTED = 3'd1,
        ST_LISTED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_BEYOND   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_FIN
    } state_t;

    // One write port and one read port per cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        block_t            wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage
`default_nettype wire

[rtl/core/bbsr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsr_if: channel interfaces of the bad block skip table
// Request, response and configuration channels, each a valid/ready word
// channel with a source and a sink modport.
// ----------------------------------------------------------------------------

// Request channel: one command word
interface bbsr_req_if;
    import bbsr_pkg::*;
    logic   valid;
    logic   ready;
    logic   cmd;
    block_t block;

    modport source (output valid, output cmd, output block, input ready);
    modport sink   (input valid, input cmd, input block, output ready);
endinterface

// Response channel: one result word
interface bbsr_rsp_if;
    import bbsr_pkg::*;
    logic                valid;
    logic                ready;
    logic [PHYS_W-1:0]   physical_block;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  bad_count;

    modport source (output valid, output physical_block, output status,
                    output bad_count, input ready);
    modport sink   (input valid, input physical_block, input status,
                    input bad_count, output ready);
endinterface

// Configuration channel: last usable block register
interface bbsr_cfg_if;
    import bbsr_pkg::*;
    logic   valid;
    logic   ready;
    block_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/bbsr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsr_ram: bad block list storage
// Single write port, single read port, registered read data. Contents are
// undefined until written; the sequencer never reads past the fill count.
// ----------------------------------------------------------------------------
module bbsr_ram (
    input  wire logic              clk,
    input  wire bbsr_pkg::ram_req_t req,
    output bbsr_pkg::block_t       rd_data
);
    import bbsr_pkg::*;

    block_t mem [TABLE_DEPTH];
    block_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/core/bad_block_skip_remap_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bad_block_skip_remap_table_top: NAND bad block skip table
// Sorted list of bad blocks; maps logical blocks and inserts new bad blocks.
// ----------------------------------------------------------------------------
// Usage:
//   req  - command word {cmd, block}. cmd 0 maps a logical block, cmd 1 marks
//          a physical block bad. One word in flight; ready only when idle.
//   rsp  - one result word per command: physical block (mapped, or the
//          marked block echoed), status and the bad count after the command.
//   cfg  - last usable block register, always ready; write only when idle.
// Flow: one list entry per cycle through one RAM read port. A map scans the
//   whole list; a mark scans it and then, when it inserts, shifts the tail
//   up from the top entry and places the block. The next word is taken once
//   the sequencer is back in idle.
// Stall: the result sits in an output register; the next command is taken
//   while it waits, but a finished command holds until the register frees.
// Reset: list empty, last usable block 4095, no result pending. The list
//   RAM itself is not cleared; entries past the count are never read.
// ----------------------------------------------------------------------------
module bad_block_skip_remap_table_top (
    input  wire logic clk,
    input  wire logic rst_n,
    bbsr_req_if.sink   req,
    bbsr_rsp_if.source rsp,
    bbsr_cfg_if.sink   cfg
);
    import bbsr_pkg::*;

    // Control state
    state_t             state_reg,     state_next;
    logic               pend_reg,      pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   total_reg,     total_next;
    block_t             last_reg,      last_next;

    // Working registers
    logic               cmd_reg,       cmd_next;
    block_t             blk_reg,       blk_next;
    logic [PHYS_W-1:0]  v_reg,         v_next;
    logic [CNT_W-1:0]   idx_reg,       idx_next;
    logic [CNT_W-1:0]   pos_reg,       pos_next;
    logic               dup_reg,       dup_next;
    logic [ADDR_W-1:0]  wa_reg,        wa_next;
    status_t            status_reg,    status_next;

    // Output word
    logic [PHYS_W-1:0]  out_phys_reg,   out_phys_next;
    status_t            out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg,  out_count_next;

    ram_req_t           ram_req;
    block_t             rd_data;
    logic [CNT_W-1:0]   idx_dec;

    bbsr_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign idx_dec = idx_reg - 1'b1;

    // Ports
    assign req.ready          = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.physical_block = out_phys_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.bad_count      = out_count_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            last_reg      <= block_t'(4095);
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        blk_reg        <= blk_next;
        v_reg          <= v_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        dup_reg        <= dup_next;
        wa_reg         <= wa_next;
        status_reg     <= status_next;
        out_phys_reg   <= out_phys_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        v_next          = v_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        dup_next        = dup_reg;
        wa_next         = wa_reg;
        status_next     = status_reg;
        out_phys_next   = out_phys_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wa_reg;
        ram_req.wr_data = rd_data;
        ram_req.rd_addr = idx_reg[ADDR_W-1:0];

        // config write
        if (cfg.valid)
        begin
            last_next = cfg.data;
        end

        // result taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                pend_next = 1'b0;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    blk_next   = req.block;
                    v_next     = {1'b0, req.block};
                    idx_next   = '0;
                    pos_next   = '0;
                    dup_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end

            // walk the list in ascending order, one entry per cycle
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_MARK)
                    begin
                        if (rd_data == blk_reg)
                        begin
                            dup_next = 1'b1;
                        end
                        if (rd_data < blk_reg)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else if ({1'b0, rd_data} <= v_reg)
                    begin
                        v_next = v_reg + 1'b1;
                    end
                end

                if (idx_reg < total_reg)
                begin
                    ram_req.rd_addr = idx_reg[ADDR_W-1:0];
                    idx_next        = idx_reg + 1'b1;
                    pend_next       = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (cmd_reg == CMD_MAP)
                        begin
                            status_next = (v_reg > {1'b0, last_reg}) ? ST_BEYOND
                                                                     : ST_MAPPED;
                            state_next  = S_FIN;
                        end
                        else if (dup_reg)
                        begin
                            status_next = ST_LISTED;
                            state_next  = S_FIN;
                        end
                        else if (total_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            idx_next   = total_reg;
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            // move the tail up one slot, top entry first
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = wa_reg;
                    ram_req.wr_data = rd_data;
                end

                if (idx_reg > pos_reg)
                begin
                    ram_req.rd_addr = idx_dec[ADDR_W-1:0];
                    wa_next         = idx_reg[ADDR_W-1:0];
                    idx_next        = idx_dec;
                    pend_next       = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            // drop the new block into its slot
            S_PLACE:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = pos_reg[ADDR_W-1:0];
                ram_req.wr_data = blk_reg;
                total_next      = total_reg + 1'b1;
                status_next     = ST_INSERTED;
                state_next      = S_FIN;
            end

            // hand the result to the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_phys_next   = v_reg;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_W'(total_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[bench/bad_block_skip_remap_table_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_block_skip_remap_table_top_test: bench for the bad block skip table
// Drives map and mark words through the request channel, writes the last
// usable block register between phases, and checks every result word against
// a local model of the sorted bad block list or a fixed directed result.
// ----------------------------------------------------------------------------
module bad_block_skip_remap_table_top_test;
    import bbsr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_DIRECTED  = 22;
    localparam int SHOW_MAX    = 10;

    typedef struct packed {
        logic [PHYS_W-1:0]  phys;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      op;
        block_t    blk;
        logic      typed;
        result_t   exp;
    } dir_row_t;

    localparam result_t NO_CHECK = '{'0, ST_MAPPED, '0};

    // Directed words; fixed results only where the list is trivially known
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_WORD, CMD_MAP,  12'd0,    1'b1, '{13'd0,    ST_MAPPED,   7'd0}},
        '{ROW_WORD, CMD_MAP,  12'd4095, 1'b1, '{13'd4095, ST_MAPPED,   7'd0}},
        '{ROW_WORD, CMD_MARK, 12'd4095, 1'b1, '{13'd4095, ST_INSERTED, 7'd1}},
        '{ROW_WORD, CMD_MARK, 12'd4095, 1'b1, '{13'd4095, ST_LISTED,   7'd1}},
        '{ROW_WORD, CMD_MAP,  12'd4095, 1'b1, '{13'd4096, ST_BEYOND,   7'd1}},
        '{ROW_WORD, CMD_MARK, 12'd0,    1'b1, '{13'd0,    ST_INSERTED, 7'd2}},
        '{ROW_WORD, CMD_MAP,  12'd0,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MARK, 12'd1,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd0,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MARK, 12'hAAA,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MARK, 12'h555,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'h554,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'hAAA,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MARK, 12'h555,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd4091, 1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd4090, 1'b0, NO_CHECK},
        '{ROW_CFG,  CMD_MAP,  12'd0,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd0,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MARK, 12'd2,    1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd1,    1'b0, NO_CHECK},
        '{ROW_CFG,  CMD_MAP,  12'hFFF,  1'b0, NO_CHECK},
        '{ROW_WORD, CMD_MAP,  12'd4090, 1'b0, NO_CHECK}
    };

    logic clk;
    logic rst_n;

    bbsr_req_if req_ch ();
    bbsr_rsp_if rsp_ch ();
    bbsr_cfg_if cfg_ch ();

    bad_block_skip_remap_table_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Model state: sorted bad list and the last usable block register
    block_t  bad_blocks [$];
    block_t  last_usable;
    result_t pending_results [$];
    result_t got_word;
    result_t want_word;
    int      mismatches;
    int      cycles;
    int      sender_gap_pct;
    int      sink_stall_pct;

    always #CLK_HALF clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[bad_block_skip_remap_table_top] ERROR");
            $finish;
        end
    end

    // Result sink with random stalls
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got_word = '{rsp_ch.physical_block, status_t'(rsp_ch.status), rsp_ch.bad_count};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result word: phys %0d status %0d count %0d",
                             got_word.phys, got_word.status, got_word.count);
            end
            else
            begin
                want_word = pending_results.pop_front();
                if (got_word !== want_word)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: expected phys %0d status %0d count %0d, got phys %0d status %0d count %0d",
                                 want_word.phys, want_word.status, want_word.count,
                                 got_word.phys, got_word.status, got_word.count);
                end
            end
        end
    end

    // Map walks the list upward; mark checks duplicate, then full, then inserts
    function automatic result_t apply_word(input logic op, input block_t blk);
        result_t     res;
        int unsigned v;
        int          pos;
        bit          dup;
        res.phys = PHYS_W'(blk);
        if (op == CMD_MAP)
        begin
            v = 32'(blk);
            foreach (bad_blocks[i])
                if (bad_blocks[i] <= v)
                    v++;
            res.phys   = v[PHYS_W-1:0];
            res.status = (v > last_usable) ? ST_BEYOND : ST_MAPPED;
        end
        else
        begin
            dup = 1'b0;
            foreach (bad_blocks[i])
                if (bad_blocks[i] == blk)
                    dup = 1'b1;
            if (dup)
                res.status = ST_LISTED;
            else if (bad_blocks.size() >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < bad_blocks.size() && bad_blocks[pos] < blk)
                    pos++;
                bad_blocks.insert(pos, blk);
                res.status = ST_INSERTED;
            end
        end
        res.count = COUNT_W'(bad_blocks.size());
        return res;
    endfunction

    // Present one request word and record its prediction once taken
    task automatic send_word(input logic op, input block_t blk, input logic typed,
                             input result_t typed_exp);
        result_t exp;
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.block <= blk;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        exp = apply_word(op, blk);
        if (typed)
            exp = typed_exp;
        pending_results.push_back(exp);
    endtask

    // Hold the sender until every predicted word has come back
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write; called at a falling edge with the block idle
    task automatic write_limit(input block_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        last_usable = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic block_t near_listed();
        if (bad_blocks.size() == 0)
            return block_t'($urandom);
        return block_t'(int'(bad_blocks[$urandom_range(bad_blocks.size() - 1)])
                        + int'($urandom_range(6)) - 3);
    endfunction

    // Logical blocks: near listed entries, near the usable edge, extremes
    function automatic block_t pick_map_block();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return near_listed();
        if (r < 55)
            return block_t'(int'(last_usable) - bad_blocks.size()
                            + int'($urandom_range(4)) - 2);
        if (r < 62)
            return $urandom_range(1) ? block_t'('1) : block_t'('0);
        return block_t'($urandom);
    endfunction

    // Marks: many duplicates and neighbors, some fresh or extreme blocks
    function automatic block_t pick_mark_block();
        int r;
        r = $urandom_range(99);
        if (r < 30 && bad_blocks.size() != 0)
            return bad_blocks[$urandom_range(bad_blocks.size() - 1)];
        if (r < 45)
            return near_listed();
        if (r < 50)
            return $urandom_range(1) ? block_t'('1) : block_t'('0);
        return block_t'($urandom);
    endfunction

    // One random phase at a given register value and idle mix
    task automatic run_phase(input int items, input int mark_pct, input int gap_pct,
                             input int stall_pct, input block_t limit_val);
        logic   op;
        block_t blk;
        drain();
        write_limit(limit_val);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2 || $urandom_range(99) == 0)
                drain();
            op  = ($urandom_range(99) < mark_pct) ? CMD_MARK : CMD_MAP;
            blk = (op == CMD_MARK) ? pick_mark_block() : pick_map_block();
            send_word(op, blk, 1'b0, NO_CHECK);
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cycles         = 0;
        mismatches     = 0;
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_MAP;
        req_ch.block   = '0;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        bad_blocks.delete();
        last_usable    = '1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
            begin
                drain();
                write_limit(DIRECTED_ROWS[r].blk);
            end
            else
                send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].blk,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
        end

        // Random phases; the list fills during the second one
        run_phase(300, 15, 10, 50, block_t'($urandom_range(1024, 3071)));
        run_phase(300, 25, 50, 10, block_t'($urandom_range(3900, 4094)));
        run_phase(300, 35, 0, 0, block_t'('1));

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[bad_block_skip_remap_table_top] OK");
        else
            $display("[bad_block_skip_remap_table_top] ERROR");
        $finish;
    end

endmodule
